@@ design/ssq_pkg.sv @@
`default_nettype none

package ssq_pkg;

  // Queue geometry and field widths.
  localparam int QUEUE_DEPTH    = 64;
  localparam int THREAD_ID_BITS = 16;
  localparam int TIME_W         = 63;
  localparam int ID_W           = 16;
  localparam int ADDR_W         = $clog2(QUEUE_DEPTH);
  localparam int CNT_W          = $clog2(QUEUE_DEPTH + 1);

  // All ones in the time field means no wake-up is pending.
  localparam logic [TIME_W-1:0] NO_WAKE = '1;

  localparam logic OP_SLEEP = 1'b0;
  localparam logic OP_TICK  = 1'b1;

  typedef enum logic [1:0] {
    KIND_SLEEP_OK   = 2'd0,
    KIND_WOKEN      = 2'd1,
    KIND_NONE_WOKEN = 2'd2,
    KIND_FULL       = 2'd3
  } kind_t;

  typedef struct packed {
    logic              operation;
    logic [ID_W-1:0]   thread_id;
    logic [TIME_W-1:0] wake_time;
    logic              from_idle;
    logic [TIME_W-1:0] now;
  } in_item_t;

  typedef struct packed {
    kind_t             kind;
    logic [ID_W-1:0]   woken_id;
    logic [TIME_W-1:0] next_wakeup;
    logic              last;
  } out_item_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic  capture;
    logic  sleep_upd;
    logic  ins_init;
    logic  mv_wr;
    logic  new_wr;
    logic  scan_init;
    logic  scan_step;
    logic  scan_done;
    logic  tick_empty;
    logic  rd_head;
    logic  pop;
    logic  push;
    kind_t kind;
  } ssq_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic is_tick;
    logic from_idle;
    logic full;
    logic empty;
    logic ins_one;
    logic rd_ge;
    logic rd_le;
    logic scan_end;
    logic woken_zero;
    logic woken_one;
    logic out_free;
  } ssq_stat_t;

endpackage

`default_nettype wire

@@ design/ssq_ctrl.sv @@
`default_nettype none

module ssq_ctrl
  import ssq_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      in_valid,
  output logic           in_ready,
  input  wire ssq_stat_t stat,
  output ssq_cmd_t       cmd
);

  typedef enum logic [7:0] {
    ST_IDLE      = 8'b0000_0001,
    ST_DECODE    = 8'b0000_0010,
    ST_SHIFT     = 8'b0000_0100,
    ST_INS_WR    = 8'b0000_1000,
    ST_TICK_SCAN = 8'b0001_0000,
    ST_TICK_CHK  = 8'b0010_0000,
    ST_TICK_OUT  = 8'b0100_0000,
    ST_RESP      = 8'b1000_0000
  } ssq_state_t;

  ssq_state_t state_r, state_nxt;
  kind_t      kind_r, kind_nxt;

  always_comb begin
    state_nxt = state_r;
    kind_nxt  = kind_r;
    cmd       = '0;
    cmd.kind  = kind_r;
    in_ready  = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_nxt   = ST_DECODE;
        end
      end
      ST_DECODE: begin
        if (stat.is_tick) begin
          if (stat.empty) begin
            cmd.tick_empty = 1'b1;
            kind_nxt       = KIND_NONE_WOKEN;
            state_nxt      = ST_RESP;
          end else begin
            cmd.scan_init = 1'b1;
            state_nxt     = ST_TICK_SCAN;
          end
        end else if (!stat.from_idle && stat.full) begin
          kind_nxt  = KIND_FULL;
          state_nxt = ST_RESP;
        end else begin
          cmd.sleep_upd = 1'b1;
          kind_nxt      = KIND_SLEEP_OK;
          if (stat.from_idle) begin
            state_nxt = ST_RESP;
          end else begin
            cmd.ins_init = 1'b1;
            state_nxt    = stat.empty ? ST_INS_WR : ST_SHIFT;
          end
        end
      end
      ST_SHIFT: begin
        if (stat.rd_ge) begin
          cmd.mv_wr = 1'b1;
          if (stat.ins_one) begin
            state_nxt = ST_INS_WR;
          end
        end else begin
          state_nxt = ST_INS_WR;
        end
      end
      ST_INS_WR: begin
        cmd.new_wr = 1'b1;
        state_nxt  = ST_RESP;
      end
      ST_TICK_SCAN: begin
        if (stat.rd_le && !stat.scan_end) begin
          cmd.scan_step = 1'b1;
        end else begin
          cmd.scan_done = 1'b1;
          state_nxt     = ST_TICK_CHK;
        end
      end
      ST_TICK_CHK: begin
        if (stat.woken_zero) begin
          kind_nxt  = KIND_NONE_WOKEN;
          state_nxt = ST_RESP;
        end else begin
          cmd.rd_head = 1'b1;
          state_nxt   = ST_TICK_OUT;
        end
      end
      ST_TICK_OUT: begin
        if (stat.out_free) begin
          cmd.pop = 1'b1;
          if (stat.woken_one) begin
            state_nxt = ST_IDLE;
          end
        end
      end
      ST_RESP: begin
        if (stat.out_free) begin
          cmd.push  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      kind_r  <= KIND_SLEEP_OK;
    end else begin
      state_r <= state_nxt;
      kind_r  <= kind_nxt;
    end
  end

endmodule

`default_nettype wire

@@ design/ssq_datapath.sv @@
`default_nettype none

module ssq_datapath
  import ssq_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire in_item_t in_data,
  input  wire logic     out_ready,
  output logic          out_valid,
  output out_item_t     out_data,
  input  wire ssq_cmd_t cmd,
  output ssq_stat_t     stat
);

  typedef struct packed {
    logic [TIME_W-1:0]         t;
    logic [THREAD_ID_BITS-1:0] id;
  } entry_t;

  // Maps a position in the ring, counted from the head, to a memory address.
  function automatic logic [ADDR_W-1:0] ring_addr(input logic [ADDR_W-1:0] base,
                                                  input logic [ADDR_W-1:0] offs);
    logic [ADDR_W:0] sum;
    sum = {1'b0, base} + {1'b0, offs};
    if (sum >= (ADDR_W + 1)'(QUEUE_DEPTH)) begin
      sum = sum - (ADDR_W + 1)'(QUEUE_DEPTH);
    end
    return sum[ADDR_W-1:0];
  endfunction

  entry_t mem [QUEUE_DEPTH];
  entry_t rd_data_r;

  logic [ADDR_W-1:0]         head_r, head_nxt;
  logic [CNT_W-1:0]          count_r, count_nxt;
  logic [TIME_W-1:0]         earliest_r, earliest_nxt;
  logic                      req_tick_r, req_idle_r;
  logic [THREAD_ID_BITS-1:0] req_id_r;
  logic [TIME_W-1:0]         req_time_r, req_now_r;
  logic [ADDR_W-1:0]         ins_r, ins_nxt;
  logic [ADDR_W-1:0]         scan_r, scan_nxt;
  logic [CNT_W-1:0]          woken_r, woken_nxt;
  logic [TIME_W-1:0]         final_r, final_nxt;
  logic                      out_valid_r, out_valid_nxt;
  out_item_t                 out_data_r, out_data_nxt;

  logic              rd_en, wr_en;
  logic [ADDR_W-1:0] rd_addr, wr_addr;
  entry_t            wr_data;
  logic              out_free;

  assign out_free = !out_valid_r || out_ready;

  always_comb begin
    stat.is_tick    = req_tick_r;
    stat.from_idle  = req_idle_r;
    stat.full       = (count_r == CNT_W'(QUEUE_DEPTH));
    stat.empty      = (count_r == '0);
    stat.ins_one    = (ins_r == ADDR_W'(1));
    stat.rd_ge      = (rd_data_r.t >= req_time_r);
    stat.rd_le      = (rd_data_r.t <= req_now_r);
    stat.scan_end   = ((CNT_W'(scan_r) + CNT_W'(1)) == count_r);
    stat.woken_zero = (woken_r == '0);
    stat.woken_one  = (woken_r == CNT_W'(1));
    stat.out_free   = out_free;
  end

  // Memory access and queue bookkeeping.
  always_comb begin
    rd_en        = 1'b0;
    rd_addr      = head_r;
    wr_en        = 1'b0;
    wr_addr      = ring_addr(head_r, ins_r);
    wr_data      = rd_data_r;
    head_nxt     = head_r;
    count_nxt    = count_r;
    earliest_nxt = earliest_r;
    ins_nxt      = ins_r;
    scan_nxt     = scan_r;
    woken_nxt    = woken_r;
    final_nxt    = final_r;

    if (cmd.sleep_upd) begin
      if (earliest_r == NO_WAKE || earliest_r > req_time_r) begin
        earliest_nxt = req_time_r;
      end
    end
    if (cmd.ins_init) begin
      ins_nxt = count_r[ADDR_W-1:0];
      rd_en   = !stat.empty;
      rd_addr = ring_addr(head_r, ADDR_W'(count_r - CNT_W'(1)));
    end
    if (cmd.mv_wr) begin
      wr_en   = 1'b1;
      ins_nxt = ins_r - ADDR_W'(1);
      rd_en   = !stat.ins_one;
      rd_addr = ring_addr(head_r, ins_r - ADDR_W'(2));
    end
    if (cmd.new_wr) begin
      wr_en      = 1'b1;
      wr_data.t  = req_time_r;
      wr_data.id = req_id_r;
      count_nxt  = count_r + CNT_W'(1);
    end
    if (cmd.scan_init) begin
      scan_nxt = '0;
      rd_en    = 1'b1;
      rd_addr  = head_r;
    end
    if (cmd.scan_step) begin
      scan_nxt = scan_r + ADDR_W'(1);
      rd_en    = 1'b1;
      rd_addr  = ring_addr(head_r, scan_r + ADDR_W'(1));
    end
    if (cmd.scan_done) begin
      if (stat.rd_le) begin
        woken_nxt = CNT_W'(scan_r) + CNT_W'(1);
        final_nxt = NO_WAKE;
      end else begin
        woken_nxt = CNT_W'(scan_r);
        final_nxt = rd_data_r.t;
      end
    end
    if (cmd.tick_empty) begin
      woken_nxt = '0;
      final_nxt = NO_WAKE;
    end
    if (cmd.rd_head) begin
      rd_en   = 1'b1;
      rd_addr = head_r;
    end
    if (cmd.pop) begin
      head_nxt  = ring_addr(head_r, ADDR_W'(1));
      count_nxt = count_r - CNT_W'(1);
      woken_nxt = woken_r - CNT_W'(1);
      rd_en     = !stat.woken_one;
      rd_addr   = ring_addr(head_r, ADDR_W'(1));
      if (stat.woken_one) begin
        earliest_nxt = final_r;
      end
    end
    if (cmd.push && cmd.kind == KIND_NONE_WOKEN) begin
      earliest_nxt = final_r;
    end
  end

  // Result register; it frees up in the same cycle the consumer takes it.
  always_comb begin
    out_data_nxt  = out_data_r;
    out_valid_nxt = out_valid_r && !out_ready;
    if (cmd.push) begin
      out_valid_nxt        = 1'b1;
      out_data_nxt.kind    = cmd.kind;
      out_data_nxt.woken_id = '0;
      out_data_nxt.next_wakeup = (cmd.kind == KIND_NONE_WOKEN) ? final_r : earliest_r;
      out_data_nxt.last    = 1'b1;
    end
    if (cmd.pop) begin
      out_valid_nxt            = 1'b1;
      out_data_nxt.kind        = KIND_WOKEN;
      out_data_nxt.woken_id    = ID_W'(rd_data_r.id);
      out_data_nxt.next_wakeup = final_r;
      out_data_nxt.last        = stat.woken_one;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      req_tick_r <= (in_data.operation == OP_TICK);
      req_idle_r <= in_data.from_idle;
      req_id_r   <= THREAD_ID_BITS'(in_data.thread_id);
      req_time_r <= in_data.wake_time;
      req_now_r  <= in_data.now;
    end
    ins_r      <= ins_nxt;
    scan_r     <= scan_nxt;
    woken_r    <= woken_nxt;
    final_r    <= final_nxt;
    out_data_r <= out_data_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r      <= '0;
      count_r     <= '0;
      earliest_r  <= NO_WAKE;
      out_valid_r <= 1'b0;
    end else begin
      head_r      <= head_nxt;
      count_r     <= count_nxt;
      earliest_r  <= earliest_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

`default_nettype wire

@@ design/sorted_sleep_wakeup_queue.sv @@
// Sorted sleep/wake-up queue. Holds up to QUEUE_DEPTH sleeping threads in a
// ring buffer kept in order of wake time. A sleep request inserts its thread
// before the first entry whose time is equal or later, so the newest of equal
// times comes first, and lowers the earliest pending wake time; a sleep from
// the idle thread only lowers that time. Any other sleep on a full queue is
// rejected with kind 3 and changes nothing. A tick request releases every
// entry due at or before the given time, in queue order, one result each with
// last on the final one; a tick that wakes nobody gives a single kind 2
// result. Every result of a request carries the earliest wake time left after
// the whole request, all ones meaning none. Requests are handled one at a
// time, through a queue memory with one read and one write port. A sleep into
// a non-empty queue moves each queued entry whose time is equal to or later
// than the new one up by one place, and a tick scans the due entries from the
// head and then gives one result per woken thread. The receiver holding off a
// result stalls the request. A new request is taken while the last result
// still waits in the output register. No clearing pass is needed after reset.
`default_nettype none

module sorted_sleep_wakeup_queue
  import ssq_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      in_valid,
  output logic           in_ready,
  input  wire in_item_t  in_data,
  output logic           out_valid,
  input  wire logic      out_ready,
  output out_item_t      out_data
);

  // Command and status between the sequencer and the queue datapath.
  ssq_cmd_t  cmd;
  ssq_stat_t stat;

  // The controller walks each request through its steps: decode, shifting
  // entries up to open a slot, scanning due entries and releasing them.
  ssq_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  // The datapath owns the queue memory, the head and count, the earliest
  // wake time and the result register.
  ssq_datapath u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .out_ready (out_ready),
    .out_valid (out_valid),
    .out_data  (out_data),
    .cmd       (cmd),
    .stat      (stat)
  );

endmodule

`default_nettype wire

@@ design/ssq_checker.sv @@
`default_nettype none

module ssq_checker
  import ssq_pkg::*;
(
  input wire logic      clk,
  input wire logic      rst_n,
  input wire logic      in_valid,
  input wire logic      in_ready,
  input wire in_item_t  in_data,
  input wire logic      out_valid,
  input wire logic      out_ready,
  input wire out_item_t out_data
);

  // A result that is not taken stays put.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  // A request that is not taken stays put.
  a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_ready |=> in_valid && $stable(in_data))
    else $error("request changed while stalled");

  // Only wake results can be followed by more results of the same request.
  a_single_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.kind != KIND_WOKEN |-> out_data.last)
    else $error("non-wake result without last");

  // Results other than wakes carry no thread id.
  a_id_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.kind != KIND_WOKEN |-> out_data.woken_id == '0)
    else $error("thread id on a non-wake result");

  // Requests are worked one at a time.
  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("second request taken while busy");

endmodule

bind sorted_sleep_wakeup_queue ssq_checker u_ssq_checker (.*);

`default_nettype wire
